// ----- design/xcr_pkg.sv -----
// Shared types and constants of the XMODEM checksum receiver.
package xcr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned ERR_W   = 4;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_A_W = 2;

	localparam logic [BYTE_W-1:0] CH_SOH = 8'd1;
	localparam logic [BYTE_W-1:0] CH_EOT = 8'd4;
	localparam logic [BYTE_W-1:0] CH_ACK = 8'd6;
	localparam logic [BYTE_W-1:0] CH_NAK = 8'd21;

	localparam logic [ERR_W-1:0]  ERR_MAX  = 4'd15;
	localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

	localparam logic [CFG_A_W-1:0] REG_HDR_TIMEOUT  = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_BYTE_TIMEOUT = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_ERR_LIMIT    = 2'd2;

	localparam logic [TICK_W-1:0] RST_HDR_TIMEOUT  = 16'd600;
	localparam logic [TICK_W-1:0] RST_BYTE_TIMEOUT = 16'd100;
	localparam logic [ERR_W-1:0]  RST_ERR_LIMIT    = 4'd5;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HUNT  = 3'd1,
		PH_NUM   = 3'd2,
		PH_COMP  = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM   = 3'd5,
		PH_DRAIN = 3'd6,
		PH_DONE  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_COMMIT    = 2'd1,
		EV_DISCARD   = 2'd2,
		EV_DUPLICATE = 2'd3
	} block_event_t;

	typedef enum logic [1:0] {
		ST_RUNNING  = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_ABORTED  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [TICK_W-1:0] header_timeout_ticks;
		logic [TICK_W-1:0] byte_timeout_ticks;
		logic [ERR_W-1:0]  error_limit;
	} cfg_t;

	typedef struct packed {
		logic              reply_valid;
		logic [BYTE_W-1:0] reply_byte;
		logic              data_valid;
		logic [BYTE_W-1:0] data_byte;
		logic [IDX_W-1:0]  data_index;
		block_event_t      block_event;
		logic [BYTE_W-1:0] block_number;
		status_t           session_status;
		logic [ERR_W-1:0]  error_count;
	} result_t;

	typedef struct packed {
		phase_t            phase;
		logic [BYTE_W-1:0] expected_block;
		logic [BYTE_W-1:0] current_block;
		logic [BYTE_W-1:0] running_sum;
		logic [ERR_W-1:0]  errors_seen;
		logic [TICK_W-1:0] idle_ticks;
		logic              drain_reply_ack;
		logic              bad_block;
	} rx_state_t;

endpackage

// ----- design/xcr_in_stage.sv -----
// Input register of the receiver: holds one accepted event until the engine takes it.
module xcr_in_stage
	import xcr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  item_t s_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

// ----- design/xcr_engine.sv -----
// Protocol engine: receiver state and the single-step reaction to one event.
module xcr_engine
	import xcr_pkg::*;
#(
	parameter int unsigned SECTOR_BYTES = 128
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item_s1,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int unsigned POS_W = $clog2(SECTOR_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTOR_BYTES - 1);

	rx_state_t         st_q, st_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [TICK_W-1:0] idle_inc;
	logic [TICK_W-1:0] limit;
	logic [ERR_W-1:0]  err_bump;
	logic [BYTE_W-1:0] next_block;
	logic              in_block;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			pos_q <= '0;
		end else if (advance) begin
			st_q  <= st_n;
			pos_q <= pos_n;
		end
	end

	assign idle_inc   = (st_q.idle_ticks != TICK_MAX) ? st_q.idle_ticks + 1'b1 : st_q.idle_ticks;
	assign limit      = (st_q.phase == PH_HUNT) ? cfg.header_timeout_ticks
	                                            : cfg.byte_timeout_ticks;
	assign err_bump   = (st_q.errors_seen != ERR_MAX) ? st_q.errors_seen + 1'b1
	                                                  : st_q.errors_seen;
	assign next_block = st_q.expected_block + 1'b1;
	assign in_block   = (st_q.phase == PH_DATA) || (st_q.phase == PH_SUM);

	always_comb begin
		st_n   = st_q;
		pos_n  = pos_q;
		result = '0;
		case (item_s1.cmd)
			CMD_START: begin
				if (in_block) begin
					result.block_event  = EV_DISCARD;
					result.block_number = st_q.current_block;
				end
				st_n             = '0;
				st_n.phase       = PH_HUNT;
				pos_n            = '0;
				result.reply_valid = 1'b1;
				result.reply_byte  = CH_NAK;
			end
			CMD_TICK: begin
				if (st_q.phase != PH_IDLE && st_q.phase != PH_DONE) begin
					st_n.idle_ticks = idle_inc;
					if (idle_inc >= limit) begin
						if (st_q.phase == PH_DRAIN) begin
							result.reply_valid   = 1'b1;
							result.reply_byte    = st_q.drain_reply_ack ? CH_ACK : CH_NAK;
							st_n.idle_ticks      = '0;
							st_n.drain_reply_ack = 1'b0;
							if (st_q.errors_seen >= cfg.error_limit) begin
								st_n.phase     = PH_DONE;
								st_n.bad_block = 1'b1;
							end else begin
								st_n.phase = PH_HUNT;
							end
						end else begin
							if (in_block) begin
								result.block_event  = EV_DISCARD;
								result.block_number = st_q.current_block;
							end
							st_n.errors_seen     = err_bump;
							st_n.phase           = PH_DRAIN;
							st_n.drain_reply_ack = 1'b0;
							st_n.idle_ticks      = '0;
						end
					end
				end
			end
			CMD_BYTE: begin
				if (st_q.phase != PH_IDLE && st_q.phase != PH_DONE) begin
					st_n.idle_ticks = '0;
					case (st_q.phase)
						PH_HUNT: begin
							if (item_s1.rx_byte == CH_SOH) begin
								st_n.phase = PH_NUM;
							end else if (item_s1.rx_byte == CH_EOT) begin
								result.reply_valid = 1'b1;
								result.reply_byte  = CH_ACK;
								st_n.phase         = PH_DONE;
								st_n.bad_block     = 1'b0;
							end
						end
						PH_NUM: begin
							st_n.current_block = item_s1.rx_byte;
							st_n.phase         = PH_COMP;
						end
						PH_COMP: begin
							if ((st_q.current_block ^ item_s1.rx_byte) != 8'hFF) begin
								st_n.errors_seen     = err_bump;
								st_n.phase           = PH_DRAIN;
								st_n.drain_reply_ack = 1'b0;
							end else if (st_q.current_block == next_block) begin
								st_n.phase       = PH_DATA;
								st_n.running_sum = '0;
								pos_n            = '0;
							end else if (st_q.current_block == st_q.expected_block) begin
								result.block_event   = EV_DUPLICATE;
								result.block_number  = st_q.current_block;
								st_n.phase           = PH_DRAIN;
								st_n.drain_reply_ack = 1'b1;
							end else begin
								st_n.errors_seen     = err_bump;
								st_n.phase           = PH_DRAIN;
								st_n.drain_reply_ack = 1'b0;
							end
						end
						PH_DATA: begin
							result.data_valid = 1'b1;
							result.data_byte  = item_s1.rx_byte;
							result.data_index = pos_q[IDX_W-1:0];
							st_n.running_sum  = st_q.running_sum + item_s1.rx_byte;
							if (pos_q == POS_LAST) begin
								pos_n      = '0;
								st_n.phase = PH_SUM;
							end else begin
								pos_n = pos_q + 1'b1;
							end
						end
						PH_SUM: begin
							result.block_number = st_q.current_block;
							if (item_s1.rx_byte == st_q.running_sum) begin
								result.block_event  = EV_COMMIT;
								result.reply_valid  = 1'b1;
								result.reply_byte   = CH_ACK;
								st_n.errors_seen    = '0;
								st_n.expected_block = st_q.current_block;
								st_n.phase          = PH_HUNT;
							end else begin
								result.block_event   = EV_DISCARD;
								st_n.errors_seen     = err_bump;
								st_n.phase           = PH_DRAIN;
								st_n.drain_reply_ack = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		if (st_n.phase == PH_DONE) begin
			result.session_status = st_n.bad_block ? ST_ABORTED : ST_COMPLETE;
		end else begin
			result.session_status = ST_RUNNING;
		end
		result.error_count = st_n.errors_seen;
	end

endmodule

// ----- design/xcr_out_stage.sv -----
// Result register: holds one result until the downstream side takes it.
module xcr_out_stage
	import xcr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	output logic    advance,
	input  result_t result,
	output logic    m_tvalid,
	input  logic    m_tready,
	output result_t result_q
);

	logic valid_q;

	assign advance  = valid_s1 && (!valid_q || m_tready);
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

endmodule

// ----- design/xmodem_checksum_receiver_top.sv -----
// Top level of the XMODEM checksum receiver.
//
// Slave stream: one event per transfer; s_tuser holds the command (received
// byte, tick or start), s_tdata the received line byte.
// Master stream: exactly one result per event: reply flag and byte, data
// flag, byte and index, block event and number, session status and error
// count.
// Configuration: cfg_wr_en writes cfg_wdata into the register at cfg_index
// (header timeout, byte timeout, error limit); write only while idle.
// Flow: an accepted event waits in the input register and its result in the
// result register, which drives m_tvalid; while m_tready is high one event per
// cycle is sustained, set by the single registered step of the protocol engine.
// Reset: both stream registers empty, receiver idle, registers at defaults.
// Stall: while m_tready is low the result register holds; one further event
// waits in the input register and then s_tready drops.
module xmodem_checksum_receiver_top
	import xcr_pkg::*;
#(
	parameter int unsigned SECTOR_BYTES = 128
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] rx_byte
	input  logic [1:0]         s_tuser,   // [1:0] command
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] reply_byte, [15:8] data_byte, [22:16] data_index, [24:23] block_event,
	// [32:25] block_number, [34:33] session_status, [38:35] error_count, [39] zero
	output logic [39:0]        m_tdata,
	output logic [1:0]         m_tuser,   // [0] reply_valid, [1] data_valid
	input  logic               cfg_wr_en,
	input  logic [CFG_A_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	cfg_t    cfg_q;
	item_t   s_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_timeout_ticks <= RST_HDR_TIMEOUT;
			cfg_q.byte_timeout_ticks   <= RST_BYTE_TIMEOUT;
			cfg_q.error_limit          <= RST_ERR_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HDR_TIMEOUT:  cfg_q.header_timeout_ticks <= cfg_wdata;
				REG_BYTE_TIMEOUT: cfg_q.byte_timeout_ticks   <= cfg_wdata;
				REG_ERR_LIMIT:    cfg_q.error_limit          <= cfg_wdata[ERR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s_item.cmd     = cmd_t'(s_tuser);
	assign s_item.rx_byte = s_tdata;

	xcr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	xcr_engine #(
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	xcr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.advance  (advance),
		.result   (result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.result_q (result_q)
	);

	assign m_tuser = {result_q.data_valid, result_q.reply_valid};
	assign m_tdata = {1'b0, result_q.error_count, result_q.session_status,
	                  result_q.block_number, result_q.block_event, result_q.data_index,
	                  result_q.data_byte, result_q.reply_byte};

endmodule

// ----- design/xcr_checker.sv -----
// Port-level checks of the receiver's result stream, bound to the top level.
module xcr_checker
	import xcr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic [7:0] reply_byte;
	logic [1:0] block_event;
	logic [3:0] error_count;

	assign reply_byte  = m_tdata[7:0];
	assign block_event = m_tdata[24:23];
	assign error_count = m_tdata[38:35];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_reply_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] && (reply_byte == CH_ACK || reply_byte == CH_NAK))
		|| (!m_tuser[0] && reply_byte == 8'd0))
		else $error("bad reply byte");

	a_data_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && block_event == EV_NONE)
		else $error("data byte mixed with block event or reply");

	a_commit_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && block_event == EV_COMMIT |->
		m_tuser[0] && reply_byte == CH_ACK && error_count == 4'd0)
		else $error("commit without ACK or error reset");

endmodule

bind xmodem_checksum_receiver_top xcr_checker u_xcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
